FILE: design/ctrgb_pkg.sv
`timescale 1ns / 1ps

package ctrgb_pkg;

  localparam logic [15:0] K_MIN     = 16'd1000;
  localparam logic [15:0] K_MAX     = 16'd40000;
  localparam logic [15:0] K_KNEE    = 16'd6600;
  localparam logic [15:0] K_BLUE0   = 16'd1900;
  localparam logic [12:0] DIV100_MUL = 13'd5243;
  localparam int          DIV100_SH  = 19;

  localparam logic [63:0] DEC8    = 64'd100000000;
  localparam logic [63:0] LN2_NUM = 64'd693147181;
  localparam logic [63:0] LN2_DEN = 64'd1000000000;
  localparam logic [63:0] RED_MUL = 64'd32969872745;
  localparam logic [63:0] RED_POW = 64'd13320476;
  localparam logic [63:0] GLO_MUL = 64'd9947080259;
  localparam logic [63:0] GLO_OFF = 64'd16111956817;
  localparam logic [63:0] GHI_MUL = 64'd28812216953;
  localparam logic [63:0] GHI_POW = 64'd7551485;
  localparam logic [63:0] BLU_MUL = 64'd13851773122;
  localparam logic [63:0] BLU_OFF = 64'd30504479273;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_w;
    v = v_in;
    res = '0;
    bit_w = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bit_w > v) bit_w = bit_w >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_w != 0) begin
        if (v >= res + bit_w) begin
          v = v - (res + bit_w);
          res = (res >> 1) + bit_w;
        end else begin
          res = res >> 1;
        end
        bit_w = bit_w >> 2;
      end
    end
    return res;
  endfunction

  // log2(1 + idx/2^a) in Q.f, square-and-compare on a Q30 value
  function automatic logic [63:0] log_rom_val(input logic [63:0] idx, input int f,
                                              input int a);
    logic [63:0] y;
    logic [63:0] res;
    y = ((64'd1 << a) + idx) << (30 - a);
    res = '0;
    for (int k = 0; k < f; k++) begin
      y = (y * y) >> 30;
      res = res << 1;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        res = res | 64'd1;
      end
    end
    return res;
  endfunction

  // 2^(idx/2^a) in Q30
  function automatic logic [63:0] exp_rom_val(input logic [63:0] idx, input int a);
    logic [63:0] m;
    logic [63:0] root;
    m = 64'd1 << 30;
    root = isqrt64(64'd1 << 61);
    for (int j = 1; j <= a; j++) begin
      if (((idx >> (a - j)) & 64'd1) != 0) m = (m * root) >> 30;
      root = isqrt64(root << 30);
    end
    return m;
  endfunction

  // restoring long division, elaboration use only
  function automatic logic [127:0] udiv128(input logic [127:0] num, input logic [127:0] den);
    logic [127:0] rem;
    logic [127:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 127; i >= 0; i--) begin
      rem = {rem[126:0], num[i]};
      if (rem >= den) begin
        rem = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // ceil(2^s * n / d)
  function automatic logic [127:0] recip(input logic [63:0] n, input logic [63:0] d,
                                         input int s);
    return udiv128((128'(n) << s) + 128'(d) - 128'd1, 128'(d));
  endfunction

  function automatic int bitlen(input logic [127:0] v);
    int r;
    r = 0;
    for (int i = 0; i < 128; i++) begin
      if (v[i]) r = i + 1;
    end
    return r;
  endfunction

endpackage

FILE: design/ctrgb_cmul.sv
`timescale 1ns / 1ps

// y = floor(x * N / D), two stages: partial products, then sum and shift.
module ctrgb_cmul #(
  parameter int          XW = 20,
  parameter int          YW = 20,
  parameter logic [63:0] N  = 64'd1,
  parameter logic [63:0] D  = 64'd1,
  parameter int          S  = 48
) (
  input  logic          clk_i,
  input  logic [1:0]    en_i,
  input  logic [XW-1:0] x_i,
  output logic [YW-1:0] y_o
);

  localparam logic [127:0] M  = ctrgb_pkg::recip(N, D, S);
  localparam int           MW = ctrgb_pkg::bitlen(M);
  localparam int           HW = MW - 32;
  localparam int           PW = XW + MW;
  localparam logic [31:0]  M_LO = M[31:0];
  localparam logic [HW-1:0] M_HI = M[MW-1:32];

  logic [XW+31:0]   pp_lo_q;
  logic [XW+HW-1:0] pp_hi_q;
  logic [PW-1:0]    sum;
  logic [YW-1:0]    y_q;

  assign sum = {pp_hi_q, 32'b0} + PW'(pp_lo_q);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pp_lo_q <= (XW+32)'(x_i) * (XW+32)'(M_LO);
      pp_hi_q <= (XW+HW)'(x_i) * (XW+HW)'(M_HI);
    end
    if (en_i[1]) begin
      y_q <= YW'(sum >> S);
    end
  end

  assign y_o = y_q;

endmodule

FILE: design/color_temperature_to_rgb.sv
`timescale 1ns / 1ps

// Color temperature to RGB, blackbody curve fit in fixed point.
// Input stream: s_axis_tdata carries a temperature in whole kelvin; values
// outside 1000..40000 are clamped. Output stream: m_axis_tdata carries
// red, green and blue bytes, one result item per input item, in order.
// Throughput is one item per cycle while the receiver takes items. The depth is
// set by the log2 lookup, two constant-multiply pairs on the power path (log to
// exponent, exponent to scale) and the 2^x lookup between them.
// Each of the 13 stages carries a valid bit and advances when it is empty
// or its successor advances, so bubbles are squeezed out and s_axis_tready
// stays high while any stage can still take an item.
// When the receiver stalls, the last stage holds its item and the stages
// behind it fill up; s_axis_tready drops once all are full. Nothing is
// lost or repeated. Reset empties all stages; there is no other state.
module color_temperature_to_rgb #(
  parameter int FRAC_BITS       = 16,
  parameter int TABLE_ADDR_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] kelvin
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

  localparam int F   = FRAC_BITS;
  localparam int A   = TABLE_ADDR_BITS;
  localparam int XW  = F + 9;
  localparam int MBW = $clog2(XW);
  localparam int LW  = F + 4;
  localparam int NW  = F + 3;
  localparam int QW  = F + 1;
  localparam int EW  = F + 1;
  localparam int CW  = F + 10;
  localparam int NS  = 13;

  localparam logic [XW-1:0] T60 = XW'(60) << F;
  localparam logic [XW-1:0] T10 = XW'(10) << F;
  localparam logic [CW-1:0] GOFF =
    CW'(ctrgb_pkg::udiv128(128'(ctrgb_pkg::GLO_OFF) << F, 128'(ctrgb_pkg::DEC8)));
  localparam logic [CW-1:0] BOFF =
    CW'(ctrgb_pkg::udiv128(128'(ctrgb_pkg::BLU_OFF) << F, 128'(ctrgb_pkg::DEC8)));

  typedef struct packed {
    logic lo;   // kelvin <= 6600
    logic bhi;  // kelvin >= 6600
    logic bz;   // kelvin <= 1900
  } flags_t;

  // constant tables
  logic [F-1:0] fr_tbl  [128];
  logic [F-1:0] log_tbl [2**A];
  logic [30:0]  exp_tbl [2**A];

  for (genvar i = 0; i < 128; i++) begin : g_fr
    assign fr_tbl[i] = F'(ctrgb_pkg::udiv128(128'(i) << F, 128'd100));
  end
  for (genvar i = 0; i < 2**A; i++) begin : g_tbl
    assign log_tbl[i] = F'(ctrgb_pkg::log_rom_val(64'(i), F, A));
    assign exp_tbl[i] = 31'(ctrgb_pkg::exp_rom_val(64'(i), A));
  end

  function automatic logic [7:0] sat_byte(input logic [CW-1:0] v);
    logic [CW-F-1:0] w;
    w = (CW-F)'(v >> F);
    return (w > (CW-F)'(255)) ? 8'hFF : w[7:0];
  endfunction

  // stage handshake
  logic [NS:1] vld_q;
  logic [NS:1] en;
  flags_t      flg_q [NS:1];
  flags_t      flg_d;

  always_comb begin
    en[NS] = !vld_q[NS] || m_axis_tready;
    for (int i = NS - 1; i >= 1; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) vld_q[1] <= s_axis_tvalid;
      for (int i = 2; i <= NS; i++) begin
        if (en[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // stage 1: clamp, kelvin / 100
  logic [15:0] kc_d, kc_q;
  logic [28:0] qprod;
  logic [8:0]  qh_q;

  always_comb begin
    if (s_axis_tdata < ctrgb_pkg::K_MIN) kc_d = ctrgb_pkg::K_MIN;
    else if (s_axis_tdata > ctrgb_pkg::K_MAX) kc_d = ctrgb_pkg::K_MAX;
    else kc_d = s_axis_tdata;
    flg_d.lo  = (kc_d <= ctrgb_pkg::K_KNEE);
    flg_d.bhi = (kc_d >= ctrgb_pkg::K_KNEE);
    flg_d.bz  = (kc_d <= ctrgb_pkg::K_BLUE0);
  end

  assign qprod = 29'(kc_d) * 29'(ctrgb_pkg::DIV100_MUL);

  // stage 2: t = kelvin * 2^F / 100 from quotient and remainder
  logic [15:0]   rem16;
  logic [XW-1:0] t_q;
  assign rem16 = kc_q - 16'(16'(qh_q) * 16'd100);

  // stage 3..6: log2 of both arguments
  logic [XW-1:0]  xa_q, xb_q, xa4_q, xb4_q;
  logic [MBW-1:0] ma_d, mb_d, ma_q, mb_q;
  logic [XW+A-1:0] sha, shb;
  logic [A-1:0]   ia_q, ib_q;
  logic [3:0]     ea_q, eb_q;
  logic [LW-1:0]  la_q, lb_q;

  always_comb begin
    ma_d = '0;
    mb_d = '0;
    for (int i = 0; i < XW; i++) begin
      if (xa_q[i]) ma_d = MBW'(i);
      if (xb_q[i]) mb_d = MBW'(i);
    end
  end

  assign sha = {xa4_q, A'(0)} >> ma_q;
  assign shb = {xb4_q, A'(0)} >> mb_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      kc_q     <= kc_d;
      qh_q     <= 9'(qprod >> ctrgb_pkg::DIV100_SH);
      flg_q[1] <= flg_d;
    end
    for (int i = 2; i <= NS; i++) begin
      if (en[i]) flg_q[i] <= flg_q[i-1];
    end
    if (en[2]) t_q <= {qh_q, fr_tbl[rem16[6:0]]};
    if (en[3]) begin
      xa_q <= flg_q[2].lo ? t_q : t_q - T60;
      xb_q <= t_q - T10;
    end
    if (en[4]) begin
      xa4_q <= xa_q;
      xb4_q <= xb_q;
      ma_q  <= ma_d;
      mb_q  <= mb_d;
    end
    if (en[5]) begin
      ia_q <= sha[A-1:0];
      ib_q <= shb[A-1:0];
      ea_q <= 4'(ma_q - MBW'(F));
      eb_q <= 4'(mb_q - MBW'(F));
    end
    if (en[6]) begin
      la_q <= {ea_q, log_tbl[ia_q]};
      lb_q <= {eb_q, log_tbl[ib_q]};
    end
  end

  // stages 7..8: natural logs; stages 9..10: log curves
  logic [NW-1:0] lna, lnb;
  logic [CW-1:0] glv, blv, gl11_q, bl11_q, gl12_q, bl12_q;

  ctrgb_cmul #(.XW(LW), .YW(NW), .N(ctrgb_pkg::LN2_NUM), .D(ctrgb_pkg::LN2_DEN),
               .S(LW + 30)) u_ln_a (
    .clk_i, .en_i({en[8], en[7]}), .x_i(la_q), .y_o(lna));
  ctrgb_cmul #(.XW(LW), .YW(NW), .N(ctrgb_pkg::LN2_NUM), .D(ctrgb_pkg::LN2_DEN),
               .S(LW + 30)) u_ln_b (
    .clk_i, .en_i({en[8], en[7]}), .x_i(lb_q), .y_o(lnb));
  ctrgb_cmul #(.XW(NW), .YW(CW), .N(ctrgb_pkg::GLO_MUL), .D(ctrgb_pkg::DEC8),
               .S(NW + 27)) u_gl (
    .clk_i, .en_i({en[10], en[9]}), .x_i(lna), .y_o(glv));
  ctrgb_cmul #(.XW(NW), .YW(CW), .N(ctrgb_pkg::BLU_MUL), .D(ctrgb_pkg::DEC8),
               .S(NW + 27)) u_bl (
    .clk_i, .en_i({en[10], en[9]}), .x_i(lnb), .y_o(blv));

  // power path, index 0 red, 1 green: exponent, 2^-q, scale
  logic [QW-1:0] qv    [2];
  logic [A-1:0]  eidx_q [2];
  logic [1:0]    ek_q  [2];
  logic [EW-1:0] ev_q  [2];
  logic [CW-1:0] pv    [2];

  for (genvar c = 0; c < 2; c++) begin : g_pow
    logic [F-1:0]   f_raw, f_adj;
    logic [1:0]     k_adj;
    logic [F+A-1:0] fsh;

    ctrgb_cmul #(.XW(LW), .YW(QW),
                 .N(c == 0 ? ctrgb_pkg::RED_POW : ctrgb_pkg::GHI_POW),
                 .D(ctrgb_pkg::DEC8), .S(LW + 27)) u_q (
      .clk_i, .en_i({en[8], en[7]}), .x_i(la_q), .y_o(qv[c]));

    always_comb begin
      f_raw = qv[c][F-1:0];
      k_adj = {1'b0, qv[c][F]};
      f_adj = f_raw;
      if (f_raw != '0) begin
        k_adj = k_adj + 2'd1;
        f_adj = F'(~f_raw + 1'b1);
      end
      fsh = {f_adj, A'(0)} >> F;
    end

    always_ff @(posedge clk_i) begin
      if (en[9]) begin
        eidx_q[c] <= fsh[A-1:0];
        ek_q[c]   <= k_adj;
      end
      if (en[10]) begin
        ev_q[c] <= EW'((exp_tbl[eidx_q[c]] >> (30 - F)) >> ek_q[c]);
      end
    end

    ctrgb_cmul #(.XW(EW), .YW(CW),
                 .N(c == 0 ? ctrgb_pkg::RED_MUL : ctrgb_pkg::GHI_MUL),
                 .D(ctrgb_pkg::DEC8), .S(EW + 27)) u_pm (
      .clk_i, .en_i({en[12], en[11]}), .x_i(ev_q[c]), .y_o(pv[c]));
  end

  // stage 13: offsets and saturation
  logic [CW:0] gd, bd;
  logic [7:0]  red_q, grn_q, blu_q;

  assign gd = (CW+1)'(gl12_q) - (CW+1)'(GOFF);
  assign bd = (CW+1)'(bl12_q) - (CW+1)'(BOFF);

  always_ff @(posedge clk_i) begin
    if (en[11]) begin
      gl11_q <= glv;
      bl11_q <= blv;
    end
    if (en[12]) begin
      gl12_q <= gl11_q;
      bl12_q <= bl11_q;
    end
    if (en[13]) begin
      red_q <= flg_q[12].lo ? 8'hFF : sat_byte(pv[0]);
      if (flg_q[12].lo) grn_q <= gd[CW] ? 8'h00 : sat_byte(gd[CW-1:0]);
      else              grn_q <= sat_byte(pv[1]);
      if (flg_q[12].bhi)     blu_q <= 8'hFF;
      else if (flg_q[12].bz) blu_q <= 8'h00;
      else                   blu_q <= bd[CW] ? 8'h00 : sat_byte(bd[CW-1:0]);
    end
  end

  assign s_axis_tready = en[1];
  assign m_axis_tvalid = vld_q[NS];
  assign m_axis_tdata  = {blu_q, grn_q, red_q};

`ifndef NO_ASSERTIONS
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> vld_q[1])
    else $error("input stalled with an empty first stage");
  a_red_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[12] && en[13] && flg_q[12].lo |=> m_axis_tdata[7:0] == 8'hFF)
    else $error("red not full at low temperature");
  a_blue_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[12] && en[13] && flg_q[12].bhi |=> m_axis_tdata[23:16] == 8'hFF)
    else $error("blue not full at high temperature");
  a_blue_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[12] && en[13] && flg_q[12].bz |=> m_axis_tdata[23:16] == 8'h00)
    else $error("blue not zero below the blue threshold");
`endif

endmodule

FILE: tb/sv/tb_color_temperature_to_rgb.sv
`timescale 1ns / 1ps

module tb_color_temperature_to_rgb;

  localparam int FRAC = 16;
  localparam int ABITS = 8;
  localparam int NTAB = 1 << ABITS;
  localparam logic [63:0] ONE = 64'd1 << FRAC;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  color_temperature_to_rgb #(.FRAC_BITS(FRAC), .TABLE_ADDR_BITS(ABITS)) i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  logic [63:0] log_tab [NTAB];
  logic [63:0] pow_tab [NTAB];
  logic [15:0] kelvin_q [$];
  rgb_t        rgb_q [$];
  int          err_cnt = 0;
  int          sent_cnt = 0;
  bit          drained_once = 0;
  bit          accepted;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
    logic [63:0] v, res, b;
    v = v_in;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint log2_fix(input logic [63:0] x);
    int m;
    logic [63:0] idx;
    if (x == 0) return 0;
    m = 63;
    while (x[m] == 1'b0) m--;
    if (m >= ABITS) idx = x >> (m - ABITS);
    else idx = x << (ABITS - m);
    idx = idx & (NTAB - 1);
    return longint'(m - FRAC) * longint'(ONE) + longint'(log_tab[idx]);
  endfunction

  function automatic logic [63:0] ln_fix(input logic [63:0] x);
    longint l;
    l = log2_fix(x);
    if (l < 0) return 0;
    return (64'(l) * ctrgb_pkg::LN2_NUM) / ctrgb_pkg::LN2_DEN;
  endfunction

  // scale * x^-pw, Q.FRAC
  function automatic logic [63:0] falloff(input logic [63:0] x, input logic [63:0] scale,
                                          input logic [63:0] pw);
    longint l;
    logic [63:0] q, k, f, sh, p;
    l = log2_fix(x);
    q = (l < 0) ? 0 : (64'(l) * pw) / ctrgb_pkg::DEC8;
    k = q >> FRAC;
    f = q & (ONE - 1);
    if (f != 0) begin
      k = k + 1;
      f = ONE - f;
    end
    sh = 64'(30 - FRAC) + k;
    p = (sh >= 63) ? 64'd0 : pow_tab[(f >> (FRAC - ABITS)) & (NTAB - 1)] >> sh;
    return (p * scale) / ctrgb_pkg::DEC8;
  endfunction

  function automatic logic [7:0] sat_byte(input longint v);
    if (v < 0) return 8'd0;
    if ((v >>> FRAC) > 255) return 8'd255;
    return 8'(v >>> FRAC);
  endfunction

  function automatic rgb_t kelvin_to_rgb(input logic [15:0] kin);
    logic [63:0] k, t;
    rgb_t c;
    k = 64'(kin);
    if (k < ctrgb_pkg::K_MIN) k = ctrgb_pkg::K_MIN;
    if (k > ctrgb_pkg::K_MAX) k = ctrgb_pkg::K_MAX;
    t = (k << FRAC) / 100;
    if (t <= 66 * ONE) begin
      c.red = 8'd255;
      c.green = sat_byte(longint'((ln_fix(t) * ctrgb_pkg::GLO_MUL) / ctrgb_pkg::DEC8)
                         - longint'((ctrgb_pkg::GLO_OFF << FRAC) / ctrgb_pkg::DEC8));
    end else begin
      c.red = sat_byte(longint'(falloff(t - 60 * ONE, ctrgb_pkg::RED_MUL,
                                        ctrgb_pkg::RED_POW)));
      c.green = sat_byte(longint'(falloff(t - 60 * ONE, ctrgb_pkg::GHI_MUL,
                                          ctrgb_pkg::GHI_POW)));
    end
    if (t >= 66 * ONE) c.blue = 8'd255;
    else if (t <= 19 * ONE) c.blue = 8'd0;
    else c.blue = sat_byte(
        longint'((ln_fix(t - 10 * ONE) * ctrgb_pkg::BLU_MUL) / ctrgb_pkg::DEC8)
        - longint'((ctrgb_pkg::BLU_OFF << FRAC) / ctrgb_pkg::DEC8));
    return c;
  endfunction

  // tables: log2(1+i/N) by repeated squaring, 2^(i/N) from chained roots
  initial begin
    logic [63:0] y, r, m, root;
    for (int i = 0; i < NTAB; i++) begin
      y = (64'(NTAB) + 64'(i)) << (30 - ABITS);
      r = 0;
      for (int s = 0; s < FRAC; s++) begin
        y = (y * y) >> 30;
        r = r << 1;
        if (y >= (64'd2 << 30)) begin
          y = y >> 1;
          r = r | 1;
        end
      end
      log_tab[i] = r;
      m = 64'd1 << 30;
      root = int_sqrt(64'd1 << 61);
      for (int j = 1; j <= ABITS; j++) begin
        if ((i >> (ABITS - j)) & 1) m = (m * root) >> 30;
        root = int_sqrt(root << 30);
      end
      pow_tab[i] = m;
    end
  end

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
  end

  // stimulus: temperature edges first, then random with weight near the knees
  initial begin
    int sel;
    kelvin_q = '{16'd0, 16'd1, 16'd999, 16'd1000, 16'd1001, 16'd1899, 16'd1900,
                 16'd1901, 16'd1950, 16'd3000, 16'd6599, 16'd6600, 16'd6601, 16'd6699,
                 16'd6700, 16'd10000, 16'd39999, 16'd40000, 16'd40001, 16'd32768,
                 16'd65535, 16'h5555, 16'hAAAA};
    for (int i = 0; i < 1500; i++) begin
      sel = $urandom_range(0, 9);
      case (sel) inside
        0, 1, 2: kelvin_q.push_back(16'($urandom_range(1000, 40000)));
        3, 4:    kelvin_q.push_back(16'($urandom_range(1000, 7000)));
        5:       kelvin_q.push_back(16'($urandom));
        6:       kelvin_q.push_back(16'($urandom_range(1850, 1950)));
        7:       kelvin_q.push_back(16'($urandom_range(6500, 6700)));
        default: kelvin_q.push_back(16'($urandom_range(5000, 12000)));
      endcase
    end
  end

  // sender: bursts and gaps, one drain pause mid-run
  int gap_left = 0;
  int burst_left = 0;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else if (!s_axis_tvalid || accepted) begin
      if (sent_cnt == 700 && !drained_once) begin
        s_axis_tvalid <= 1'b0;
        if (rgb_q.size() == 0) drained_once = 1;
      end else if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (kelvin_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= kelvin_q.pop_front();
        sent_cnt++;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: randomly chosen phases of full speed, random and heavy stall
  int rx_phase = 0;
  int rx_left = 0;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_phase = $urandom_range(0, 2);
        rx_left = $urandom_range(10, 80);
      end
      rx_left--;
      case (rx_phase)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    rgb_t got, want;
    accepted = rst_ni && s_axis_tvalid && s_axis_tready;
    if (accepted) rgb_q.push_back(kelvin_to_rgb(s_axis_tdata));
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (rgb_q.size() == 0) begin
        $error("unexpected item %h", m_axis_tdata);
        err_cnt++;
      end else begin
        want = rgb_q.pop_front();
        if (got.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, got.red);
          err_cnt++;
        end
        if (got.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, got.green);
          err_cnt++;
        end
        if (got.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, got.blue);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    wait (rst_ni);
    wait (kelvin_q.size() == 0 && !s_axis_tvalid && rgb_q.size() == 0);
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0 && rgb_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
design/ctrgb_pkg.sv
design/ctrgb_cmul.sv
design/color_temperature_to_rgb.sv
tb/sv/tb_color_temperature_to_rgb.sv
